// ===== rtl/core/utf8_utf16_transcoder_macros.svh =====
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_UTF16_TRANSCODER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define UTX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define UTX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/utx_pkg.sv =====
// Shared types, constants and functions of the UTF-8 / UTF-16 transcoder.
package utx_pkg;

    localparam int UTX_QUEUE_DEPTH = 2;

    localparam logic [31:0] UTX_MAX_CODE_POINT = 32'h0010_FFFF;
    localparam logic [15:0] UTX_REPLACEMENT    = 16'hFFFD;
    localparam logic [15:0] UTX_HIGH_SURR_MIN  = 16'hD800;
    localparam logic [15:0] UTX_HIGH_SURR_MAX  = 16'hDBFF;
    localparam logic [20:0] UTX_PAIR_BIAS      = 21'h00_2400;
    localparam logic [20:0] UTX_PLANE1_BASE    = 21'h01_0000;

    localparam logic DIR_UTF8_TO_UTF16 = 1'b0;
    localparam logic DIR_UTF16_TO_UTF8 = 1'b1;

    // One code point command passed from front to back
    typedef struct packed {
        logic        dir;
        logic [31:0] value;
        logic [2:0]  total;
    } utx_cmd_t;

    // Number of trailing bytes announced by a UTF-8 lead byte
    function automatic logic [2:0] trail_count(input logic [7:0] lead);
        logic [2:0] n;
        if (lead < 8'hC0) begin
            n = 3'd0;
        end else if (lead < 8'hE0) begin
            n = 3'd1;
        end else if (lead < 8'hF0) begin
            n = 3'd2;
        end else if (lead < 8'hF8) begin
            n = 3'd3;
        end else if (lead < 8'hFC) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

    // Offset removed from the accumulated UTF-8 value, per trailing count
    function automatic logic [31:0] utf8_offset(input logic [2:0] total);
        logic [31:0] off;
        unique case (total)
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            3'd5:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/core/utx_front.sv =====
// Front end: accepts input transactions, tracks partial sequences, issues code point commands.
`include "utf8_utf16_transcoder_macros.svh"

module utx_front
    import utx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_in_unit,
    output logic        q_push,
    input  logic        q_ready,
    output utx_cmd_t    q_cmd
);

    logic        direction_reg;
    logic [2:0]  trail_left_reg,  trail_left_next;
    logic [2:0]  trail_total_reg, trail_total_next;
    logic [31:0] code_acc_reg,    code_acc_next;
    logic [15:0] high_held_reg,   high_held_next;
    logic        high_valid_reg,  high_valid_next;

    logic        accept;
    logic        issue;
    logic [7:0]  in_byte;
    logic [2:0]  lead_trail;
    logic [31:0] acc_sum;
    logic [20:0] pair_cp;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && issue;

    // Decode one input unit against the partial state of the selected direction
    always_comb begin
        trail_left_next  = trail_left_reg;
        trail_total_next = trail_total_reg;
        code_acc_next    = code_acc_reg;
        high_held_next   = high_held_reg;
        high_valid_next  = high_valid_reg;
        issue            = 1'b0;
        in_byte          = s_in_unit[7:0];
        lead_trail       = trail_count(in_byte);
        acc_sum          = {code_acc_reg[25:0], 6'b0} + {24'b0, in_byte};
        pair_cp          = {1'b0, high_held_reg[9:0], 10'b0} + {5'b0, s_in_unit}
                           + UTX_PAIR_BIAS;
        q_cmd.dir        = direction_reg;
        q_cmd.value      = {16'b0, s_in_unit};
        q_cmd.total      = 3'd0;

        if (direction_reg == DIR_UTF8_TO_UTF16) begin
            if (trail_left_reg == 3'd0) begin
                // Lead byte: start a new sequence
                code_acc_next    = {24'b0, in_byte};
                trail_total_next = lead_trail;
                trail_left_next  = lead_trail;
                q_cmd.value      = {24'b0, in_byte};
                issue            = (lead_trail == 3'd0);
            end else begin
                // Trailing byte: fold in six more bits
                code_acc_next   = acc_sum;
                trail_left_next = trail_left_reg - 3'd1;
                q_cmd.value     = acc_sum;
                q_cmd.total     = trail_total_reg;
                issue           = (trail_left_reg == 3'd1);
            end
        end else begin
            if (high_valid_reg) begin
                // Combine the held high surrogate with this unit
                high_valid_next = 1'b0;
                q_cmd.value     = {11'b0, pair_cp};
                issue           = 1'b1;
            end else if (s_in_unit >= UTX_HIGH_SURR_MIN && s_in_unit <= UTX_HIGH_SURR_MAX) begin
                high_held_next  = s_in_unit;
                high_valid_next = 1'b1;
            end else begin
                issue = 1'b1;
            end
        end
    end

    // Hold the direction and the decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg   <= DIR_UTF8_TO_UTF16;
            trail_left_reg  <= 3'd0;
            trail_total_reg <= 3'd0;
            code_acc_reg    <= 32'd0;
            high_held_reg   <= 16'd0;
            high_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                direction_reg <= cfg_wr_data;
            end
            if (accept) begin
                trail_left_reg  <= trail_left_next;
                trail_total_reg <= trail_total_next;
                code_acc_reg    <= code_acc_next;
                high_held_reg   <= high_held_next;
                high_valid_reg  <= high_valid_next;
            end
        end
    end

    `UTX_ASSERT_NOW(a_trail_within_total, 1'b1, trail_left_reg <= trail_total_reg, "trail count beyond sequence length")
    `UTX_ASSERT_NOW(a_held_is_high_surr, high_valid_reg, high_held_reg >= UTX_HIGH_SURR_MIN && high_held_reg <= UTX_HIGH_SURR_MAX, "held unit is not a high surrogate")

endmodule

// ===== rtl/core/utx_queue.sv =====
// Short command queue between the front and back ends.
`include "utf8_utf16_transcoder_macros.svh"

module utx_queue
    import utx_pkg::*;
#(
    parameter int DEPTH = UTX_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    output logic     push_ready,
    input  utx_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop,
    output utx_cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utx_cmd_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `UTX_ASSERT_NOW(a_no_push_when_full, push, count_reg != CNT_W'(DEPTH), "push into a full queue")

endmodule

// ===== rtl/core/utx_back.sv =====
// Back end: expands code point commands into output units behind an output register.
`include "utf8_utf16_transcoder_macros.svh"

module utx_back
    import utx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_pop,
    input  utx_cmd_t    q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_unit,
    output logic        m_last_unit,
    output logic        m_replaced
);

    logic [31:0] code_point;
    logic        dec_rep;
    logic [20:0] cp;
    logic [20:0] plane_off;
    logic [15:0] dec_units [4];
    logic [1:0]  dec_last_idx;

    logic        job_valid_reg;
    logic [15:0] job_units_reg [4];
    logic [1:0]  job_last_idx_reg;
    logic [1:0]  job_idx_reg;
    logic        job_rep_reg;

    logic        m_valid_reg;
    logic [15:0] out_unit_reg;
    logic        out_last_reg;
    logic        out_rep_reg;

    logic        out_free;
    logic        emit;
    logic        job_done;

    // Finish the code point and split it into units
    always_comb begin
        code_point   = q_cmd.value - utf8_offset(q_cmd.total);
        dec_rep      = (code_point > UTX_MAX_CODE_POINT);
        cp           = dec_rep ? {5'b0, UTX_REPLACEMENT} : code_point[20:0];
        plane_off    = cp - UTX_PLANE1_BASE;
        dec_units[0] = 16'd0;
        dec_units[1] = 16'd0;
        dec_units[2] = 16'd0;
        dec_units[3] = 16'd0;
        dec_last_idx = 2'd0;

        if (q_cmd.dir == DIR_UTF8_TO_UTF16) begin
            if (cp[20:16] == 5'd0) begin
                dec_units[0] = cp[15:0];
            end else begin
                dec_units[0] = {6'b110110, plane_off[19:10]};
                dec_units[1] = {6'b110111, plane_off[9:0]};
                dec_last_idx = 2'd1;
            end
        end else begin
            if (cp < 21'h80) begin
                dec_units[0] = {9'b0, cp[6:0]};
            end else if (cp < 21'h800) begin
                dec_units[0] = {8'b0, 3'b110, cp[10:6]};
                dec_units[1] = {8'b0, 2'b10, cp[5:0]};
                dec_last_idx = 2'd1;
            end else if (cp < 21'h1_0000) begin
                dec_units[0] = {8'b0, 4'b1110, cp[15:12]};
                dec_units[1] = {8'b0, 2'b10, cp[11:6]};
                dec_units[2] = {8'b0, 2'b10, cp[5:0]};
                dec_last_idx = 2'd2;
            end else begin
                dec_units[0] = {8'b0, 5'b11110, cp[20:18]};
                dec_units[1] = {8'b0, 2'b10, cp[17:12]};
                dec_units[2] = {8'b0, 2'b10, cp[11:6]};
                dec_units[3] = {8'b0, 2'b10, cp[5:0]};
                dec_last_idx = 2'd3;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_valid_reg && out_free;
    assign job_done = emit && (job_idx_reg == job_last_idx_reg);
    assign q_pop    = q_valid && (!job_valid_reg || job_done);

    // Advance the job and the output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_idx_reg   <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                job_valid_reg <= 1'b1;
                job_idx_reg   <= 2'd0;
            end else if (job_done) begin
                job_valid_reg <= 1'b0;
            end else if (emit) begin
                job_idx_reg <= job_idx_reg + 2'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load job and output payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_units_reg    <= dec_units;
            job_last_idx_reg <= dec_last_idx;
            job_rep_reg      <= dec_rep;
        end
        if (emit) begin
            out_unit_reg <= job_units_reg[job_idx_reg];
            out_last_reg <= (job_idx_reg == job_last_idx_reg);
            out_rep_reg  <= job_rep_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_unit  = out_unit_reg;
    assign m_last_unit = out_last_reg;
    assign m_replaced  = out_rep_reg;

    `UTX_ASSERT_NOW(a_idx_in_range, job_valid_reg, job_idx_reg <= job_last_idx_reg, "unit index past end of code point")
    `UTX_ASSERT_NEXT(a_stalled_job_holds, job_valid_reg && !out_free, job_valid_reg && $stable(job_idx_reg), "stalled job moved")

endmodule

// ===== rtl/core/utf8_utf16_transcoder.sv =====
// Top level of the streaming UTF-8 / UTF-16 transcoder.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_in_unit[15:0]
//   m_       out        m_valid / m_ready    m_out_unit[15:0], m_last_unit, m_replaced
//   cfg_     in         cfg_wr_en            cfg_wr_data (direction)
//
// One input transaction per cycle while each code point yields at most one output unit and m_ready stays high.
// A code point of n output units (n = 1..4) keeps the back end busy until its last unit is sent; the
// command queue (QUEUE_DEPTH entries) absorbs input meanwhile before s_ready drops.
// With no stall, the first output unit is held in the queue, then the job registers, then the output register.
// aresetn is synchronous, active low, and clears the decode state and direction (0).
module utf8_utf16_transcoder
    import utx_pkg::*;
#(
    parameter int QUEUE_DEPTH = UTX_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_in_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_unit,
    output logic        m_last_unit,
    output logic        m_replaced
);

    logic     q_push;
    logic     q_ready;
    utx_cmd_t push_cmd;
    logic     q_valid;
    logic     q_pop;
    utx_cmd_t pop_cmd;

    utx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_unit   (s_in_unit),
        .q_push      (q_push),
        .q_ready     (q_ready),
        .q_cmd       (push_cmd)
    );

    utx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (pop_cmd)
    );

    utx_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (pop_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_unit  (m_out_unit),
        .m_last_unit (m_last_unit),
        .m_replaced  (m_replaced)
    );

endmodule
